[rtl/assert_macros.svh]
// Assertion helpers for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, switched off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/ripst_pkg.sv]
package ripst_pkg;

    localparam int IDX_W     = 11;
    localparam int DATA_W    = 64;
    localparam int KIND_W    = 2;
    // Wide enough to compare indices against any supported element count.
    localparam int CMP_W     = 17;

    localparam int ELEMENTS_DEFAULT = 1024;

    localparam logic [IDX_W-1:0] ELEMENT_COUNT_RESET = 11'd1024;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_ELEMENT_COUNT_ADDR = 3'd0;

    localparam logic [KIND_W-1:0] KIND_SET       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INCREMENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVEN_SUM  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ODD_SUM   = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  left_index;
        logic [IDX_W-1:0]  right_index;
        logic [DATA_W-1:0] new_value;
    } cmd_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] range_sum;
        logic              bad_range;
    } rsp_item_t;

endpackage

[rtl/ripst_if.sv]
interface ripst_cmd_if;
    import ripst_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ripst_rsp_if;
    import ripst_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/range_increment_parity_sum_tree_core.sv]
// Range increment and parity sum engine over an array of 64-bit elements.
// Items arrive on cmd (valid/ready) and each one produces exactly one item
// on rsp: a set of one element, an increment by one of a range, or the sum
// of the even or of the odd elements of a range. Ranges are 1-based and
// inclusive; a set uses the left index only. An index of zero or beyond
// element_count, or for the other kinds a left index above the right one, is
// flagged with bad_range and a zero sum, and changes nothing. The APB port
// holds element_count at address 0. A set writes its element in ST_SETW
// before ST_DONE. An increment or a query walks the range one element per
// cycle through the single read port and one shared 64-bit adder, which
// either bumps the element it just read or adds a matching one into the
// running sum. A rejected item goes straight from ST_IDLE to ST_DONE. cmd
// is ready only between items. After reset the element memory is cleared
// one entry per cycle; cmd stays not ready meanwhile, APB writes are taken.
// A finished result waits in the output register while rsp is stalled; the
// engine then holds the next result until the register frees up.
module range_increment_parity_sum_tree_core #(
    parameter int ELEMENTS = ripst_pkg::ELEMENTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ripst_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ripst_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ripst_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    ripst_cmd_if.sink                           cmd,
    ripst_rsp_if.source                         rsp
);
    import ripst_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(ELEMENTS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SETW  = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  element_count_reg, element_count_next;
    logic [AW-1:0]     clr_ptr_reg, clr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]     end_ptr_reg, end_ptr_next;
    logic              issuing_reg, issuing_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [KIND_W-1:0] op_reg, op_next;
    logic [DATA_W-1:0] set_value_reg, set_value_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              bad_reg, bad_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_sum_reg, out_sum_next;
    logic              out_bad_reg, out_bad_next;

    logic              cfg_write;
    logic              reg_sel;
    logic              cmd_fire;
    logic [CMP_W-1:0]  bound;
    logic [CMP_W-1:0]  left_ext, right_ext;
    logic              in_bad;
    logic [AW-1:0]     left_addr, right_addr;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    logic              op_inc;
    logic              take_elem;
    logic [DATA_W-1:0] add_a, add_b, add_out;

    // Configuration port. Registers are decoded by word, so the byte lane
    // bits of paddr do not matter.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = ({paddr[APB_ADDR_W-1:2], 2'b00} == REG_ELEMENT_COUNT_ADDR);
    assign prdata    = reg_sel ? APB_DATA_W'(element_count_reg) : '0;

    always_comb
    begin
        element_count_next = element_count_reg;
        if (cfg_write && reg_sel)
        begin
            element_count_next = pwdata[IDX_W-1:0];
        end
    end

    // Range check of the incoming item against the effective bound.
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign bound     = (CMP_W'(element_count_reg) < CMP_W'(ELEMENTS)) ?
                       CMP_W'(element_count_reg) : CMP_W'(ELEMENTS);
    assign left_ext  = CMP_W'(cmd.payload.left_index);
    assign right_ext = CMP_W'(cmd.payload.right_index);
    assign left_addr  = AW'(left_ext - CMP_W'(1));
    assign right_addr = AW'(right_ext - CMP_W'(1));

    always_comb
    begin
        if (cmd.payload.kind == KIND_SET)
        begin
            in_bad = (left_ext == '0) || (left_ext > bound);
        end
        else
        begin
            in_bad = (left_ext == '0) || (right_ext == '0) ||
                     (right_ext > bound) || (left_ext > right_ext);
        end
    end

    // The shared adder: increments bump the element just read, queries add
    // a matching element into the running sum.
    assign op_inc    = (op_reg == KIND_INCREMENT);
    assign take_elem = (ram_rdata[0] == (op_reg == KIND_ODD_SUM));
    assign add_a     = op_inc ? ram_rdata : acc_reg;
    assign add_b     = op_inc ? DATA_W'(1) : (take_elem ? ram_rdata : '0);
    assign add_out   = add_a + add_b;

    assign ram_raddr = rd_ptr_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = add_out;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_ptr_reg;
                ram_wdata = '0;
            end
            ST_SETW:
            begin
                ram_we    = 1'b1;
                ram_waddr = pend_addr_reg;
                ram_wdata = set_value_reg;
            end
            ST_WALK:
            begin
                ram_we = pend_valid_reg && op_inc;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        clr_ptr_next    = clr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        end_ptr_next    = end_ptr_reg;
        issuing_next    = issuing_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        op_next         = op_reg;
        set_value_next  = set_value_reg;
        acc_next        = acc_reg;
        bad_next        = bad_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_sum_next    = out_sum_reg;
        out_bad_next    = out_bad_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_ptr_next = clr_ptr_reg + AW'(1);
                if (clr_ptr_reg == AW'(ELEMENTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next        = cmd.payload.kind;
                    set_value_next = cmd.payload.new_value;
                    bad_next       = in_bad;
                    acc_next       = '0;
                    rd_ptr_next    = left_addr;
                    end_ptr_next   = right_addr;
                    pend_addr_next = left_addr;
                    issuing_next   = 1'b1;
                    if (in_bad)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (cmd.payload.kind == KIND_SET)
                    begin
                        state_next = ST_SETW;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_SETW:
            begin
                state_next = ST_DONE;
            end
            ST_WALK:
            begin
                if (issuing_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = rd_ptr_reg;
                    if (rd_ptr_reg == end_ptr_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                    end
                end
                if (pend_valid_reg && !op_inc)
                begin
                    acc_next = add_out;
                end
                if (!issuing_reg && !pend_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_reg;
                    out_bad_next   = bad_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            element_count_reg <= ELEMENT_COUNT_RESET;
            clr_ptr_reg       <= '0;
            issuing_reg       <= 1'b0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            element_count_reg <= element_count_next;
            clr_ptr_reg       <= clr_ptr_next;
            issuing_reg       <= issuing_next;
            pend_valid_reg    <= pend_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        end_ptr_reg   <= end_ptr_next;
        pend_addr_reg <= pend_addr_next;
        op_reg        <= op_next;
        set_value_reg <= set_value_next;
        acc_reg       <= acc_next;
        bad_reg       <= bad_next;
        out_sum_reg   <= out_sum_next;
        out_bad_reg   <= out_bad_next;
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.payload.range_sum = out_sum_reg;
    assign rsp.payload.bad_range = out_bad_reg;

    ripst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ELEMENTS)
    ) u_elem_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Only increments write back during a range walk.
    `ASSERT_CLK(a_walk_write_inc, (state_reg == ST_WALK && ram_we) |-> op_inc, "walk write without increment")
    // The engine takes one item at a time.
    `ASSERT_CLK(a_one_item, cmd_fire |=> !cmd.ready, "item accepted while busy")
    // A rejected item always reports a zero sum.
    `ASSERT_CLK(a_bad_zero, (out_valid_reg && out_bad_reg) |-> (out_sum_reg == '0), "bad range with nonzero sum")
    // A pending element never lies past the end of the range.
    `ASSERT_CLK(a_pend_in_range, (state_reg == ST_WALK && pend_valid_reg) |-> (pend_addr_reg <= end_ptr_reg), "walk past range end")

endmodule

[rtl/ripst_ram.sv]
module ripst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
